// ===== src/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants of the TLV stream parser
// Parse phases, byte kinds, error codes, register indexes and the result
// record that travels from the parse core to the output stage.
// ----------------------------------------------------------------------------
package btlv_pkg;

    // Parse phase of the byte stream.
    typedef enum logic [2:0] {
        PH_TAG0 = 3'd0,
        PH_TAGN = 3'd1,
        PH_LEN0 = 3'd2,
        PH_LENN = 3'd3,
        PH_VAL  = 3'd4
    } phase_t;

    // Classification of one byte.
    localparam logic [1:0] KIND_TAG = 2'd0;
    localparam logic [1:0] KIND_LEN = 2'd1;
    localparam logic [1:0] KIND_VAL = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_LENFORM = 3'd1;
    localparam logic [2:0] ERR_TAGLONG = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;
    localparam logic [2:0] ERR_DEEP    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_TAG   = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN   = 2'd1;
    localparam logic [1:0] CFG_MAX_DEPTH = 2'd2;

    // Encoding constants of the byte format.
    localparam logic [4:0] TAG_MULTI   = 5'h1F;
    localparam logic [7:0] LEN_INDEF   = 8'h80;
    localparam int         TAG_CONS_BIT = 5;
    localparam int         LEN_LONG_BIT = 7;
    localparam int         TAG_MORE_BIT = 7;

    // Hard limit on the tag byte count.
    localparam logic [2:0] TAG_BYTES_CAP = 3'd4;

    // Result beat width on the data bus.
    localparam int OUT_DATA_W = 80;

    // Configuration register set.
    typedef struct packed {
        logic [2:0] max_tag_bytes;
        logic [2:0] max_length_bytes;
        logic [3:0] max_depth_used;
    } cfg_t;

    // One result record.
    typedef struct packed {
        logic [1:0]  byte_kind;
        logic        header_done;
        logic [31:0] tag_value;
        logic [2:0]  tag_byte_count;
        logic [31:0] value_length;
        logic        is_constructed;
        logic [3:0]  nest_level;
        logic [3:0]  elements_closed;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== src/btlv_core.sv =====
// ----------------------------------------------------------------------------
// btlv_core: parse state and single-byte step of the TLV parser
// Holds the phase, tag and length accumulators and the stack of remaining
// byte counts of the enclosing constructed elements, and computes the result
// of one byte in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module btlv_core #(
    parameter int MAX_DEPTH    = 8,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    input  btlv_pkg::cfg_t    cfg,
    output btlv_pkg::result_t result
);

    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W = (DW > 4) ? DW : 4;
    localparam int CLS_W = DW + 1;
    localparam logic [2:0] LLIM_CAP = 3'(LENGTH_WIDTH / 8);

    // Parse state.
    btlv_pkg::phase_t        phase_reg, phase_next;
    logic [31:0]             tag_acc_reg, tag_acc_next;
    logic [2:0]              tag_cnt_reg, tag_cnt_next;
    logic [2:0]              len_left_reg, len_left_next;
    logic [LENGTH_WIDTH-1:0] len_acc_reg, len_acc_next;
    logic [LENGTH_WIDTH-1:0] val_left_reg, val_left_next;
    logic                    constr_reg, constr_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [LENGTH_WIDTH-1:0] level_reg [MAX_DEPTH];

    // Step intermediates.
    logic [LENGTH_WIDTH-1:0] lvl_dec  [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]    lvl_zero;
    logic [LENGTH_WIDTH-1:0] parent_left;
    logic                    has_parent;
    logic [2:0]              tlim;
    logic [2:0]              llim;
    logic                    too_deep;
    logic [1:0]              kind;
    logic                    hd;
    logic [LENGTH_WIDTH-1:0] vlen;
    logic                    ended;
    logic [2:0]              err;
    logic                    push;
    logic [DW-1:0]           pop_cnt;
    logic                    pop_run;
    logic [CLS_W-1:0]        closed;
    logic                    clear;

    // Limits actually in force.
    assign tlim = (cfg.max_tag_bytes > btlv_pkg::TAG_BYTES_CAP) ?
                  btlv_pkg::TAG_BYTES_CAP : cfg.max_tag_bytes;
    assign llim = (cfg.max_length_bytes > LLIM_CAP) ? LLIM_CAP : cfg.max_length_bytes;
    assign too_deep = (depth_reg >= DW'(MAX_DEPTH)) ||
                      (CMP_W'(depth_reg) >= CMP_W'(cfg.max_depth_used));

    // Every open level loses one byte; flag the levels that end here.
    always_comb begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            lvl_dec[i]  = level_reg[i] - LENGTH_WIDTH'(1);
            lvl_zero[i] = (lvl_dec[i] == '0) && (i < int'(depth_reg));
        end
    end

    // Remaining bytes of the innermost enclosing element.
    assign has_parent  = (depth_reg != '0);
    assign parent_left = has_parent ? lvl_dec[AW'(depth_reg - DW'(1))] : '0;

    // Byte classification follows the phase alone.
    always_comb begin
        case (phase_reg)
            btlv_pkg::PH_TAG0: kind = btlv_pkg::KIND_TAG;
            btlv_pkg::PH_TAGN: kind = btlv_pkg::KIND_TAG;
            btlv_pkg::PH_LEN0: kind = btlv_pkg::KIND_LEN;
            btlv_pkg::PH_LENN: kind = btlv_pkg::KIND_LEN;
            btlv_pkg::PH_VAL:  kind = btlv_pkg::KIND_VAL;
            default:           kind = btlv_pkg::KIND_TAG;
        endcase
    end

    // Next parse state and the result of this byte.
    always_comb begin
        phase_next    = phase_reg;
        tag_acc_next  = tag_acc_reg;
        tag_cnt_next  = tag_cnt_reg;
        len_left_next = len_left_reg;
        len_acc_next  = len_acc_reg;
        val_left_next = val_left_reg;
        constr_next   = constr_reg;
        depth_next    = depth_reg;
        hd            = 1'b0;
        vlen          = '0;
        ended         = 1'b0;
        err           = btlv_pkg::ERR_NONE;
        push          = 1'b0;
        pop_cnt       = '0;
        pop_run       = 1'b1;
        closed        = '0;

        // Tag and length decoding.
        case (phase_reg)
            btlv_pkg::PH_TAGN: begin
                if (4'(tag_cnt_reg) + 4'd1 > 4'(tlim)) begin
                    err = btlv_pkg::ERR_TAGLONG;
                end else begin
                    tag_acc_next = {tag_acc_reg[23:0], data_byte};
                    tag_cnt_next = tag_cnt_reg + 3'd1;
                    if (!data_byte[btlv_pkg::TAG_MORE_BIT]) begin
                        phase_next = btlv_pkg::PH_LEN0;
                    end
                end
            end
            btlv_pkg::PH_LEN0: begin
                if (data_byte == btlv_pkg::LEN_INDEF) begin
                    err = btlv_pkg::ERR_LENFORM;
                end else if (data_byte[btlv_pkg::LEN_LONG_BIT]) begin
                    if (data_byte[6:0] > 7'(llim)) begin
                        err = btlv_pkg::ERR_LENFORM;
                    end else begin
                        len_left_next = data_byte[2:0];
                        len_acc_next  = '0;
                        phase_next    = btlv_pkg::PH_LENN;
                    end
                end else begin
                    hd   = 1'b1;
                    vlen = LENGTH_WIDTH'(data_byte[6:0]);
                end
            end
            btlv_pkg::PH_LENN: begin
                len_acc_next  = LENGTH_WIDTH'({len_acc_reg, data_byte});
                len_left_next = len_left_reg - 3'd1;
                if (len_left_next == 3'd0) begin
                    hd   = 1'b1;
                    vlen = len_acc_next;
                end
            end
            btlv_pkg::PH_VAL: begin
                val_left_next = val_left_reg - LENGTH_WIDTH'(1);
                if (val_left_next == '0) begin
                    ended = 1'b1;
                end
            end
            default: begin
                tag_acc_next = '0;
                tag_cnt_next = '0;
                constr_next  = 1'b0;
                if (tlim == 3'd0) begin
                    err = btlv_pkg::ERR_TAGLONG;
                end else begin
                    tag_acc_next = {24'd0, data_byte};
                    tag_cnt_next = 3'd1;
                    constr_next  = data_byte[btlv_pkg::TAG_CONS_BIT];
                    phase_next   = (data_byte[4:0] == btlv_pkg::TAG_MULTI) ?
                                   btlv_pkg::PH_TAGN : btlv_pkg::PH_LEN0;
                end
            end
        endcase

        // A finished header descends, opens a value or closes at once, or fails (overrun, depth).
        if (hd) begin
            if (has_parent && vlen > parent_left) begin
                err = btlv_pkg::ERR_OVERRUN;
            end else if (constr_next && vlen != '0) begin
                if (too_deep) begin
                    err = btlv_pkg::ERR_DEEP;
                end else begin
                    push       = 1'b1;
                    depth_next = depth_reg + DW'(1);
                    phase_next = btlv_pkg::PH_TAG0;
                end
            end else if (vlen == '0) begin
                ended = 1'b1;
            end else begin
                val_left_next = vlen;
                phase_next    = btlv_pkg::PH_VAL;
            end
        end

        // Closing an element pops every enclosing level that ends here too; else a spent parent overruns.
        if (err == btlv_pkg::ERR_NONE) begin
            if (ended) begin
                phase_next = btlv_pkg::PH_TAG0;
                for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
                    if (i < int'(depth_reg)) begin
                        if (pop_run && lvl_zero[i]) begin
                            pop_cnt = pop_cnt + DW'(1);
                        end else begin
                            pop_run = 1'b0;
                        end
                    end
                end
                depth_next = depth_reg - pop_cnt;
                closed     = CLS_W'(pop_cnt) + CLS_W'(1);
            end else if (has_parent && parent_left == '0) begin
                err = btlv_pkg::ERR_OVERRUN;
            end
        end

        // An element still open at the end of the buffer is truncated.
        if (err == btlv_pkg::ERR_NONE && end_of_buffer &&
            (phase_next != btlv_pkg::PH_TAG0 || depth_next != '0)) begin
            err = btlv_pkg::ERR_TRUNC;
        end

        if (err != btlv_pkg::ERR_NONE) begin
            hd     = 1'b0;
            vlen   = '0;
            closed = '0;
        end
    end

    assign clear = (err != btlv_pkg::ERR_NONE) || end_of_buffer;

    // Result record, taken before any return to top level.
    always_comb begin
        result.byte_kind       = kind;
        result.header_done     = hd;
        result.tag_value       = tag_acc_next;
        result.tag_byte_count  = tag_cnt_next;
        result.value_length    = hd ? 32'(vlen) : 32'd0;
        result.is_constructed  = constr_next;
        result.nest_level      = 4'(depth_reg);
        result.elements_closed = (closed > CLS_W'(15)) ? 4'd15 : 4'(closed);
        result.error_code      = err;
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= btlv_pkg::PH_TAG0;
            tag_acc_reg  <= '0;
            tag_cnt_reg  <= '0;
            len_left_reg <= '0;
            len_acc_reg  <= '0;
            val_left_reg <= '0;
            constr_reg   <= 1'b0;
            depth_reg    <= '0;
        end else if (step_en) begin
            if (clear) begin
                phase_reg    <= btlv_pkg::PH_TAG0;
                tag_acc_reg  <= '0;
                tag_cnt_reg  <= '0;
                len_left_reg <= '0;
                len_acc_reg  <= '0;
                val_left_reg <= '0;
                constr_reg   <= 1'b0;
                depth_reg    <= '0;
            end else begin
                phase_reg    <= phase_next;
                tag_acc_reg  <= tag_acc_next;
                tag_cnt_reg  <= tag_cnt_next;
                len_left_reg <= len_left_next;
                len_acc_reg  <= len_acc_next;
                val_left_reg <= val_left_next;
                constr_reg   <= constr_next;
                depth_reg    <= depth_next;
            end
        end
    end

    // Level stack: open levels count down, a descent writes the new top.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
                if (push && i == int'(depth_reg)) begin
                    level_reg[i] <= vlen;
                end else if (i < int'(depth_reg)) begin
                    level_reg[i] <= lvl_dec[i];
                end
            end
        end
    end

endmodule

// ===== src/ber_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser: byte-serial TLV stream parser
// Bytes pass the input register, then the parse step, into the result register.
// Throughput: one byte per cycle while the result side does not stall, set by the
// single-pass parse step between the input register and the result register.
// Reset: synchronous, active low; clears parse state and valid flags and
// loads the limits 4, 4 and 8. The level stack needs no clearing pass.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser #(
    parameter int MAX_DEPTH    = 8,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input bytes.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tlast,   // end_of_buffer
    // Result beats.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: header_done, tag_value[32], tag_byte_count[3], value_length[32],
    // is_constructed, nest_level[4], elements_closed[4], error_code[3].
    output logic [btlv_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                       m_tuser,   // byte_kind
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [3:0]                       cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    btlv_pkg::result_t out_reg;
    btlv_pkg::result_t step_result;
    btlv_pkg::cfg_t    cfg_reg;
    logic              step_fire;

    // A byte moves on whenever the result register is free or being drained.
    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_tag_bytes    <= 3'd4;
            cfg_reg.max_length_bytes <= 3'd4;
            cfg_reg.max_depth_used   <= 4'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                btlv_pkg::CFG_MAX_TAG:   cfg_reg.max_tag_bytes    <= cfg_data[2:0];
                btlv_pkg::CFG_MAX_LEN:   cfg_reg.max_length_bytes <= cfg_data[2:0];
                btlv_pkg::CFG_MAX_DEPTH: cfg_reg.max_depth_used   <= cfg_data;
                default: ;
            endcase
        end
    end

    btlv_core #(
        .MAX_DEPTH    (MAX_DEPTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_fire),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_last_reg),
        .cfg           (cfg_reg),
        .result        (step_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_kind;
    assign m_tdata  = {out_reg.error_code, out_reg.elements_closed, out_reg.nest_level,
                       out_reg.is_constructed, out_reg.value_length,
                       out_reg.tag_byte_count, out_reg.tag_value, out_reg.header_done};

endmodule

// ===== src/btlv_checker.sv =====
// ----------------------------------------------------------------------------
// btlv_checker: port-level checks of the TLV stream parser
// Watches the result stream for reset behavior, beat stability and the
// consistency of header, kind and error fields.
// ----------------------------------------------------------------------------
module btlv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [btlv_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);

    logic       hdr_done;
    logic [3:0] closed;
    logic [2:0] err;

    assign hdr_done = m_tdata[0];
    assign closed   = m_tdata[76:73];
    assign err      = m_tdata[79:77];

    // No result beat is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // An error beat reports no header and closes nothing.
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err != btlv_pkg::ERR_NONE |-> !hdr_done && closed == 4'd0)
        else $error("error beat carries header or close count");

    // Only a length byte completes a header.
    a_hdr_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && hdr_done |-> m_tuser == btlv_pkg::KIND_LEN)
        else $error("header completed on a non-length byte");

    // A tag byte never closes an element.
    a_tag_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == btlv_pkg::KIND_TAG |-> closed == 4'd0)
        else $error("tag byte closed an element");

endmodule

bind ber_tlv_stream_parser btlv_checker u_btlv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the TLV stream parser
// Streams TLV buffers through the parser: a handful of hand-picked corner
// cases first, then random well-formed buffers (nested, long-form lengths,
// multi-byte tags) mixed with corrupted, truncated and pure-noise buffers.
// The limits are changed between runs of buffers. A tracker mirrors the
// parse state byte by byte and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD  = 10;
    localparam int DEPTH_CAP   = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_SETTING = 245;
    localparam int SETTING_COUNT     = 7;

    typedef logic [7:0] octet_q_t[$];

    // ------------------------------------------------------------------------
    // Parse-state tracker: mirrors the parser and holds the results it owes.
    // ------------------------------------------------------------------------
    class tlv_parse_tracker;
        logic [2:0]         lim_tag;
        logic [2:0]         lim_len;
        logic [3:0]         lim_depth;
        btlv_pkg::phase_t   ph;
        logic [31:0]        tag_acc;
        logic [2:0]         tag_cnt;
        logic [2:0]         len_left;
        logic [31:0]        len_acc;
        logic [31:0]        val_left;
        logic               cons;
        logic [3:0]         depth;
        logic [31:0]        level_left [DEPTH_CAP];
        btlv_pkg::result_t  pending_results[$];
        int                 errors;
        int                 beat_count;

        function new();
            lim_tag    = 3'd4;
            lim_len    = 3'd4;
            lim_depth  = 4'd8;
            errors     = 0;
            beat_count = 0;
            foreach (level_left[i]) level_left[i] = '0;
            restart();
        endfunction

        // Back to top level, waiting for a first tag byte.
        function void restart();
            ph       = btlv_pkg::PH_TAG0;
            tag_acc  = '0;
            tag_cnt  = '0;
            len_left = '0;
            len_acc  = '0;
            val_left = '0;
            cons     = 1'b0;
            depth    = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                btlv_pkg::CFG_MAX_TAG:   lim_tag = val[2:0];
                btlv_pkg::CFG_MAX_LEN:   lim_len = val[2:0];
                btlv_pkg::CFG_MAX_DEPTH: lim_depth = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // One accepted byte: advance the parse and queue the result it owes.
        function void accept_byte(logic [7:0] b, logic last);
            logic [2:0]        tlim;
            logic [2:0]        llim;
            logic [3:0]        dlim;
            logic [3:0]        d0;
            logic [1:0]        kind;
            logic              hd;
            logic              ended;
            logic [3:0]        closed;
            logic [2:0]        err;
            logic [31:0]       vlen;
            btlv_pkg::result_t r;
            int                i;

            tlim   = (lim_tag < 3'd4) ? lim_tag : 3'd4;
            llim   = (lim_len < 3'd4) ? lim_len : 3'd4;
            dlim   = (lim_depth < 4'(DEPTH_CAP)) ? lim_depth : 4'(DEPTH_CAP);
            kind   = btlv_pkg::KIND_TAG;
            hd     = 1'b0;
            ended  = 1'b0;
            closed = '0;
            err    = btlv_pkg::ERR_NONE;
            vlen   = '0;
            d0     = depth;

            // Every open enclosing element loses one byte.
            for (i = 0; i < int'(d0); i++) level_left[i] = level_left[i] - 32'd1;

            case (ph)
                btlv_pkg::PH_TAGN: begin
                    kind = btlv_pkg::KIND_TAG;
                    if (tag_cnt + 3'd1 > tlim) begin
                        err = btlv_pkg::ERR_TAGLONG;
                    end else begin
                        tag_acc = {tag_acc[23:0], b};
                        tag_cnt = tag_cnt + 3'd1;
                        if (!b[btlv_pkg::TAG_MORE_BIT]) ph = btlv_pkg::PH_LEN0;
                    end
                end
                btlv_pkg::PH_LEN0: begin
                    kind = btlv_pkg::KIND_LEN;
                    if (b == btlv_pkg::LEN_INDEF) begin
                        err = btlv_pkg::ERR_LENFORM;
                    end else if (b[btlv_pkg::LEN_LONG_BIT]) begin
                        if (b[6:0] > 7'(llim)) begin
                            err = btlv_pkg::ERR_LENFORM;
                        end else begin
                            len_left = b[2:0];
                            len_acc  = '0;
                            ph       = btlv_pkg::PH_LENN;
                        end
                    end else begin
                        hd   = 1'b1;
                        vlen = 32'(b);
                    end
                end
                btlv_pkg::PH_LENN: begin
                    kind     = btlv_pkg::KIND_LEN;
                    len_acc  = {len_acc[23:0], b};
                    len_left = len_left - 3'd1;
                    if (len_left == 3'd0) begin
                        hd   = 1'b1;
                        vlen = len_acc;
                    end
                end
                btlv_pkg::PH_VAL: begin
                    kind     = btlv_pkg::KIND_VAL;
                    val_left = val_left - 32'd1;
                    if (val_left == 32'd0) ended = 1'b1;
                end
                default: begin
                    kind    = btlv_pkg::KIND_TAG;
                    tag_acc = '0;
                    tag_cnt = '0;
                    cons    = 1'b0;
                    if (tlim < 3'd1) begin
                        err = btlv_pkg::ERR_TAGLONG;
                    end else begin
                        tag_acc = 32'(b);
                        tag_cnt = 3'd1;
                        cons    = b[btlv_pkg::TAG_CONS_BIT];
                        ph      = (b[4:0] == btlv_pkg::TAG_MULTI) ?
                                  btlv_pkg::PH_TAGN : btlv_pkg::PH_LEN0;
                    end
                end
            endcase

            // A finished header descends, opens a value, closes, or fails (overrun, depth).
            if (hd) begin
                if (d0 > 4'd0 && vlen > level_left[d0 - 4'd1]) begin
                    err = btlv_pkg::ERR_OVERRUN;
                end else if (cons && vlen > 32'd0) begin
                    if (d0 >= dlim) begin
                        err = btlv_pkg::ERR_DEEP;
                    end else begin
                        level_left[d0[2:0]] = vlen;
                        depth = d0 + 4'd1;
                        ph    = btlv_pkg::PH_TAG0;
                    end
                end else if (vlen == 32'd0) begin
                    ended = 1'b1;
                end else begin
                    val_left = vlen;
                    ph       = btlv_pkg::PH_VAL;
                end
            end

            // Pop every enclosing element that ends together with this one; else a spent parent overruns.
            if (err == btlv_pkg::ERR_NONE) begin
                if (ended) begin
                    ph     = btlv_pkg::PH_TAG0;
                    closed = 4'd1;
                    while (depth > 4'd0 && level_left[depth - 4'd1] == 32'd0) begin
                        depth  = depth - 4'd1;
                        closed = closed + 4'd1;
                    end
                end else if (d0 > 4'd0 && level_left[d0 - 4'd1] == 32'd0) begin
                    err = btlv_pkg::ERR_OVERRUN;
                end
            end
            if (err == btlv_pkg::ERR_NONE && last &&
                (ph != btlv_pkg::PH_TAG0 || depth != 4'd0)) err = btlv_pkg::ERR_TRUNC;
            if (err != btlv_pkg::ERR_NONE) begin
                hd     = 1'b0;
                vlen   = '0;
                closed = '0;
            end

            r.byte_kind       = kind;
            r.header_done     = hd;
            r.tag_value       = tag_acc;
            r.tag_byte_count  = tag_cnt;
            r.value_length    = hd ? vlen : 32'd0;
            r.is_constructed  = cons;
            r.nest_level      = d0;
            r.elements_closed = closed;
            r.error_code      = err;
            pending_results.push_back(r);

            if (err != btlv_pkg::ERR_NONE || last) restart();
        endfunction

        task report(string what);
            errors++;
            $display("tb: beat %0d: %s", beat_count, what);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // One result beat against the oldest owed result.
        task check_result(logic [btlv_pkg::OUT_DATA_W-1:0] data, logic [1:0] kind);
            btlv_pkg::result_t want;
            beat_count++;
            if (pending_results.size() == 0) begin
                report("result beat with no byte outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("byte_kind", 32'(kind), 32'(want.byte_kind));
                check_field("header_done", 32'(data[0]), 32'(want.header_done));
                check_field("tag_value", data[32:1], want.tag_value);
                check_field("tag_byte_count", 32'(data[35:33]), 32'(want.tag_byte_count));
                check_field("value_length", data[67:36], want.value_length);
                check_field("is_constructed", 32'(data[68]), 32'(want.is_constructed));
                check_field("nest_level", 32'(data[72:69]), 32'(want.nest_level));
                check_field("elements_closed", 32'(data[76:73]),
                            32'(want.elements_closed));
                check_field("error_code", 32'(data[79:77]), 32'(want.error_code));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and the parser itself.
    // ------------------------------------------------------------------------
    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [btlv_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = '0;
    logic [3:0]                      cfg_data = '0;

    tlv_parse_tracker tracker = new();
    int  cycle_count = 0;
    int  rx_hold = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  bytes_sent = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ber_tlv_stream_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap(rx_quiet);
        end
    end

    // Sample every handshake at the rising edge; results before new bytes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) tracker.accept_byte(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------------

    // Single-byte or multi-byte tag; some multi-byte tags run to five bytes.
    function automatic octet_q_t build_tag(bit cons_flag);
        octet_q_t   q;
        logic [7:0] b;
        int         extra;
        int         i;
        b = 8'($urandom_range(0, 255));
        b[btlv_pkg::TAG_CONS_BIT] = cons_flag;
        if ($urandom_range(0, 3) == 0) begin
            b[4:0] = btlv_pkg::TAG_MULTI;
            q.push_back(b);
            extra = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
            for (i = 0; i < extra; i++) begin
                b = 8'($urandom_range(0, 255));
                b[btlv_pkg::TAG_MORE_BIT] = (i != extra - 1);
                q.push_back(b);
            end
        end else begin
            if (b[4:0] == btlv_pkg::TAG_MULTI) b[4:0] = 5'($urandom_range(0, 30));
            q.push_back(b);
        end
        return q;
    endfunction

    // Short or long form, with padded long forms and a few illegal forms.
    function automatic octet_q_t build_length(int unsigned len);
        octet_q_t q;
        int       r;
        int       nb;
        int       i;
        r = $urandom_range(0, 99);
        if (r == 0) begin
            q.push_back(btlv_pkg::LEN_INDEF);
        end else if (r < 3) begin
            q.push_back(btlv_pkg::LEN_INDEF | 8'($urandom_range(5, 7)));
        end else if (len < 128 && r < 75) begin
            q.push_back(8'(len));
        end else begin
            nb = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
            nb = nb + $urandom_range(0, 4 - nb);
            q.push_back(btlv_pkg::LEN_INDEF | 8'(nb));
            for (i = nb - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
        end
        return q;
    endfunction

    // One element; a chain nests a single child at every level.
    function automatic octet_q_t build_element(int levels, bit chain);
        octet_q_t    body;
        octet_q_t    kid;
        octet_q_t    q;
        bit          cons_flag;
        int          n;
        int unsigned len;
        cons_flag = (levels > 0) && (chain || $urandom_range(0, 99) < 55);
        if (cons_flag) begin
            n = chain ? 1 : $urandom_range(0, 2);
            repeat (n) begin
                kid  = build_element(levels - 1, chain);
                body = {body, kid};
            end
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        len = body.size();
        // Now and then the length disagrees with the content.
        if ($urandom_range(0, 19) == 0) begin
            if (len > 0 && $urandom_range(0, 1) == 1) len = len - 1;
            else len = len + $urandom_range(1, 3);
        end
        q   = build_tag(cons_flag);
        kid = build_length(len);
        q   = {q, kid, body};
        return q;
    endfunction

    // One byte on the input stream; starts and ends at a falling edge.
    task automatic send_byte(logic [7:0] d, logic last);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // One buffer: well-formed, truncated or noise.
    task automatic send_buffer();
        octet_q_t octets;
        octet_q_t elem;
        int       r;
        int       levels;
        bit       chain;
        int       i;
        tx_quiet = ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 12) begin
            // Noise, often behind a header that announces a huge value.
            if ($urandom_range(0, 1) == 1) begin
                octets.push_back(8'($urandom_range(0, 255)) & ~8'h1F);
                octets.push_back(btlv_pkg::LEN_INDEF | 8'd4);
                repeat (4) octets.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(1, 12)) octets.push_back(8'($urandom_range(0, 255)));
            for (i = 0; i < octets.size(); i++)
                send_byte(octets[i], i == octets.size() - 1 || $urandom_range(0, 15) == 0);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 99);
                chain  = (r >= 90);
                levels = (r < 70) ? $urandom_range(0, 2) : (r < 90) ? 3 : $urandom_range(4, 9);
                elem   = build_element(levels, chain);
                octets = {octets, elem};
            end
            // Cut some buffers short inside an element.
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(1, octets.size());
                while (octets.size() > r) void'(octets.pop_back());
            end
            for (i = 0; i < octets.size(); i++)
                send_byte(octets[i], i == octets.size() - 1);
        end
    endtask

    // Let every owed result come back with the input channel idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_limits(int tag_lim, int len_lim, int depth_lim);
        write_cfg(btlv_pkg::CFG_MAX_TAG, 4'(tag_lim));
        write_cfg(btlv_pkg::CFG_MAX_LEN, 4'(len_lim));
        write_cfg(btlv_pkg::CFG_MAX_DEPTH, 4'(depth_lim));
        cfg_valid <= 1'b0;
    endtask

    // Hand-picked corner cases; bit 8 marks the last byte of a buffer.
    logic [8:0] corner_bytes [$] = '{
        9'h004, 9'h080,                                 // indefinite length
        9'h004, 9'h085,                                 // too many length bytes
        9'h0FF, 9'h07F, 9'h000,                         // two-byte tag, empty
        9'h01F, 9'h081, 9'h082, 9'h083, 9'h004,         // tag one byte too long
        9'h030, 9'h003, 9'h002, 9'h001, 9'h1AA,         // nested, closes two
        9'h030, 9'h002, 9'h004, 9'h005,                 // child overruns parent
        9'h004, 9'h084, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, // huge length
        9'h100                                          // buffer ends in value
    };

    initial begin
        int s;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_quiet = 1'b1;
        foreach (corner_bytes[i]) send_byte(corner_bytes[i][7:0], corner_bytes[i][8]);

        for (s = 0; s < SETTING_COUNT; s++) begin
            if (s > 0) begin
                drain();
                case (s)
                    1: set_limits(1, 1, 0);
                    2: set_limits(4, 4, 8);
                    3: set_limits(2, 2, 3);
                    4: set_limits(3, 4, 1);
                    default: set_limits($urandom_range(1, 4), $urandom_range(1, 4),
                                        $urandom_range(0, 8));
                endcase
            end
            bytes_sent = 0;
            while (bytes_sent < ITEMS_PER_SETTING) send_buffer();
        end

        drain();
        repeat (5) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
